// ===== hw/rtl/tkf_pkg.sv =====
// ============================================================================
// tkf_pkg
// Shared widths, constants and control types of the two-axis Kalman filter.
// ============================================================================
package tkf_pkg;

  // Field and state widths
  localparam int SampleW = 16;  // raw gyro sample, signed counts
  localparam int EstW    = 32;  // estimate, signed Q16.16
  localparam int VarW    = 32;  // variance, unsigned Q2.30
  localparam int GainW   = 31;  // gain, unsigned Q1.30 (0 .. 1.0)
  localparam int FracW   = 30;  // fraction bits of gain and variances
  localparam int CfgIdxW = 2;   // register index on the config channel

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_MEASUREMENT_NOISE = CfgIdxW'(1);

  // Reset values
  localparam logic [VarW-1:0]  PROCESS_NOISE_RST     = VarW'(10737);
  localparam logic [VarW-1:0]  MEASUREMENT_NOISE_RST = VarW'(10737418);
  localparam logic [VarW-1:0]  ERR_VAR_RST           = VarW'(32'h4000_0000);
  localparam logic [GainW-1:0] ONE_Q30               = GainW'(32'h4000_0000);

  // Sequencing strobes shared by the lanes and the merge stage
  typedef struct packed {
    logic load;    // word accepted: lanes capture error magnitude
    logic mul_en;  // gain ready: products are registered
    logic commit;  // results written to state and output register
  } tkf_ctrl_t;

  // Gain divider status
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [GainW-1:0] gain;
  } tkf_div_t;

endpackage

// ===== hw/rtl/tkf_in_if.sv =====
// ============================================================================
// tkf_in_if
// Input channel: one pair of raw gyro samples per word.
// ============================================================================
interface tkf_in_if;
  import tkf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_z;
  logic signed [SampleW-1:0] sample_y;

  modport source (output valid, output sample_z, output sample_y, input ready);
  modport sink (input valid, input sample_z, input sample_y, output ready);
endinterface

// ===== hw/rtl/tkf_out_if.sv =====
// ============================================================================
// tkf_out_if
// Output channel: one pair of filtered estimates per word.
// ============================================================================
interface tkf_out_if;
  import tkf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [EstW-1:0] filtered_z;
  logic signed [EstW-1:0] filtered_y;

  modport source (output valid, output filtered_z, output filtered_y, input ready);
  modport sink (input valid, input filtered_z, input filtered_y, output ready);
endinterface

// ===== hw/rtl/tkf_cfg_if.sv =====
// ============================================================================
// tkf_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface tkf_cfg_if;
  import tkf_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [VarW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tkf_gain_div.sv =====
// ============================================================================
// tkf_gain_div
// Restoring divider for the Kalman gain Pp * 2^30 / (Pp + R), one bit a cycle.
// ============================================================================
module tkf_gain_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tkf_pkg::VarW-1:0] pp_i,
  input  logic [tkf_pkg::VarW-1:0] rnoise_i,
  output tkf_pkg::tkf_div_t        st_o
);
  import tkf_pkg::*;

  localparam int DenW = VarW + 1;
  localparam int RemW = VarW + 2;
  localparam int CntW = $clog2(GainW + 1);

  logic [DenW-1:0]  den_q;
  logic [RemW-1:0]  rem_q;
  logic [GainW-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic             ge;
  logic [RemW-1:0]  rem_sub;
  logic [RemW-1:0]  rem_sel;

  // One trial subtraction; remainder stays below den, so the shift fits
  assign ge      = rem_q >= RemW'(den_q);
  assign rem_sub = rem_q - RemW'(den_q);
  assign rem_sel = ge ? rem_sub : rem_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(GainW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: quotient starts at bit 30 since Pp never exceeds Pp + R
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= DenW'(pp_i) + DenW'(rnoise_i);
      rem_q <= RemW'(pp_i);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_sel[RemW-2:0], 1'b0};
      quo_q <= {quo_q[GainW-2:0], ge};
    end
  end

  // Zero denominator gives a gain of one
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign st_o.gain = (den_q == '0) ? ONE_Q30 : quo_q;

endmodule

// ===== hw/rtl/tkf_lane.sv =====
// ============================================================================
// tkf_lane
// One axis of the filter: holds the estimate and forms its correction.
// ============================================================================
module tkf_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tkf_pkg::tkf_ctrl_t                 ctrl_i,
  input  logic signed [tkf_pkg::SampleW-1:0] sample_i,
  input  logic [tkf_pkg::GainW-1:0]          gain_i,
  output logic signed [tkf_pkg::EstW-1:0]    est_next_o
);
  import tkf_pkg::*;

  localparam int DiffW = EstW + 1;
  localparam int ProdW = EstW + GainW;
  localparam int RndW  = ProdW - FracW + 1;

  logic signed [EstW-1:0]  estimate_q;
  logic [EstW-1:0]         mag_q;
  logic                    neg_q;
  logic [ProdW-1:0]        prod_q;

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        diff_abs;
  logic [RndW-1:0]         delta;
  logic signed [RndW-1:0]  est_ext;
  logic signed [RndW-1:0]  est_sum;

  // Innovation: sample in Q16.16 minus the estimate; magnitude below 2^32
  assign diff     = DiffW'($signed({sample_i, 16'h0000})) - DiffW'(estimate_q);
  assign diff_abs = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

  // Correction rounded to nearest, ties away from zero, applied by sign
  assign delta      = RndW'(prod_q[ProdW-1:FracW]) + RndW'(prod_q[FracW-1]);
  assign est_ext    = RndW'(estimate_q);
  assign est_sum    = neg_q ? est_ext - $signed(delta) : est_ext + $signed(delta);
  assign est_next_o = est_sum[EstW-1:0];

  // Estimate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estimate_q <= '0;
    end else if (ctrl_i.commit) begin
      estimate_q <= est_next_o;
    end
  end

  // Magnitude capture and gain product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q <= diff_abs[EstW-1:0];
      neg_q <= diff[DiffW-1];
    end
    if (ctrl_i.mul_en) begin
      prod_q <= ProdW'(mag_q) * ProdW'(gain_i);
    end
  end

endmodule

// ===== hw/rtl/tkf_merge.sv =====
// ============================================================================
// tkf_merge
// Merge stage: updates the shared error variance and holds the output word.
// ============================================================================
module tkf_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tkf_pkg::tkf_ctrl_t              ctrl_i,
  input  logic [tkf_pkg::GainW-1:0]       gain_i,
  input  logic [tkf_pkg::VarW-1:0]        pp_i,
  input  logic signed [tkf_pkg::EstW-1:0] est_z_i,
  input  logic signed [tkf_pkg::EstW-1:0] est_y_i,
  output logic [tkf_pkg::VarW-1:0]        err_var_o,
  output logic                            out_free_o,
  tkf_out_if.source                       out_o
);
  import tkf_pkg::*;

  localparam int ProdW = VarW + GainW;

  logic [VarW-1:0]        err_var_q;
  logic [ProdW-1:0]       prod_q;
  logic                   out_valid_q;
  logic signed [EstW-1:0] out_z_q;
  logic signed [EstW-1:0] out_y_q;

  // Output register is free when empty or being taken this cycle
  assign out_free_o = !out_valid_q || out_o.ready;

  // (1 - K) * Pp, registered before the shift back to Q2.30
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ProdW'(ONE_Q30 - gain_i) * ProdW'(pp_i);
    end
    if (ctrl_i.commit) begin
      out_z_q <= est_z_i;
      out_y_q <= est_y_i;
    end
  end

  // Shared error variance and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_var_q   <= ERR_VAR_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.commit) begin
        err_var_q   <= prod_q[FracW+VarW-1:FracW];
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign err_var_o        = err_var_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.filtered_z = out_z_q;
  assign out_o.filtered_y = out_y_q;

endmodule

// ===== hw/rtl/two_axis_scalar_kalman_filter_core.sv =====
// ============================================================================
// two_axis_scalar_kalman_filter_core
// Two-axis scalar Kalman filter for raw gyro samples, one shared variance.
// ============================================================================
// Use:
//   cfg_i  : register writes (index 0 process noise Q, 1 measurement noise R,
//            both UQ2.30); always ready, other indexes are ignored. Write only
//            while no word is in flight.
//   in_i   : one word carries a Z and a Y raw sample (signed 16-bit counts).
//   out_o  : one word per input word, the new Z and Y estimates in Q16.16.
// Timing:
//   A word goes from acceptance to output valid in these steps: loading the
//   gain divider, its quotient bits (one a cycle), handing the finished
//   gain on, the lane and variance products, and commit. The next word is
//   taken in the cycle after commit, so a new word is not accepted while
//   one is still being worked on; the serial divider sets the pace.
// Reset:
//   Estimates clear to zero, the error variance to 1.0, Q and R to their
//   defaults; the output register empties.
// Stall:
//   A result waits in the output register; the next word is accepted and
//   worked on meanwhile and holds at commit until that register is taken.
// ============================================================================
module two_axis_scalar_kalman_filter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tkf_cfg_if.sink   cfg_i,
  tkf_in_if.sink    in_i,
  tkf_out_if.source out_o
);
  import tkf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRED = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e          state_q;
  state_e          state_d;

  logic [VarW-1:0] process_noise_q;
  logic [VarW-1:0] measurement_noise_q;
  logic [VarW-1:0] pp_q;
  logic [VarW:0]   pp_sum;
  logic [VarW-1:0] err_var;
  logic            accept;
  logic            out_free;
  tkf_ctrl_t       ctrl;
  tkf_div_t        div_st;
  logic signed [EstW-1:0] est_z_next;
  logic signed [EstW-1:0] est_y_next;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_noise_q     <= PROCESS_NOISE_RST;
      measurement_noise_q <= MEASUREMENT_NOISE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PROCESS_NOISE:     process_noise_q     <= cfg_i.data;
        REG_MEASUREMENT_NOISE: measurement_noise_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Predicted variance P + Q, saturating
  assign pp_sum = (VarW + 1)'(err_var) + (VarW + 1)'(process_noise_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pp_q <= pp_sum[VarW] ? {VarW{1'b1}} : pp_sum[VarW-1:0];
    end
  end

  // Sequencer
  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign ctrl.load   = accept;
  assign ctrl.mul_en = (state_q == ST_MUL);
  assign ctrl.commit = (state_q == ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_PRED;
      ST_PRED: state_d = ST_DIV;
      ST_DIV:  if (div_st.done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Gain unit
  tkf_gain_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_PRED),
    .pp_i     (pp_q),
    .rnoise_i (measurement_noise_q),
    .st_o     (div_st)
  );

  // Axis lanes
  tkf_lane u_lane_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (in_i.sample_z),
    .gain_i     (div_st.gain),
    .est_next_o (est_z_next)
  );

  tkf_lane u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (in_i.sample_y),
    .gain_i     (div_st.gain),
    .est_next_o (est_y_next)
  );

  // Merge stage
  tkf_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .gain_i     (div_st.gain),
    .pp_i       (pp_q),
    .est_z_i    (est_z_next),
    .est_y_i    (est_y_next),
    .err_var_o  (err_var),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_accept_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_PRED)
    else $error("accepted word did not move to prediction");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_ready_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_st.busy)
    else $error("input ready while divider busy");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> div_st.gain <= ONE_Q30)
    else $error("gain above one");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis scalar Kalman filter core. A
// bit-accurate filter model tracks both estimates and the shared error
// variance. Every word accepted on the input predicts one pair of
// estimates, and a monitor compares each output word with the oldest
// prediction. Directed words come first: sample extremes, unity gain with
// a zero denominator, variance saturation and ignored register indexes.
// Random phases follow, each with its own noise setting, and all but
// every fourth with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tkf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          RAND_PHASES = 10;
  localparam int          PHASE_WORDS = 155;
  localparam int          TAIL_CYCLES = 40;

  // Indexes that decode to no register
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = CfgIdxW'(3);

  typedef struct packed {
    logic signed [EstW-1:0] z;
    logic signed [EstW-1:0] y;
  } estimate_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tkf_cfg_if cfg_if ();
  tkf_in_if  in_if ();
  tkf_out_if out_if ();

  two_axis_scalar_kalman_filter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Filter model state
  logic [EstW-1:0] track_z;
  logic [EstW-1:0] track_y;
  logic [VarW-1:0] shared_err_var;
  logic [VarW-1:0] noise_q;
  logic [VarW-1:0] noise_r;

  estimate_pair_t pending_estimates[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  bit          idling_on   = 1'b1;
  bit          feeding     = 1'b0;
  bit          cfg_driving = 1'b0;

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still awaited", $time, pending_estimates.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random gap lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // Noise setting for a phase, extremes included
  function automatic logic [VarW-1:0] pick_variance(input bit for_r);
    case ($urandom_range(0, 9))
      0:       return for_r ? VarW'(1) : VarW'(0);
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return for_r ? MEASUREMENT_NOISE_RST : PROCESS_NOISE_RST;
      4, 5, 6: return VarW'($urandom_range(0, 1 << 20));
      7, 8:    return VarW'($urandom) & 32'h7FFF_FFFF;
      default: return for_r ? VarW'(0) : VarW'($urandom);
    endcase
  endfunction

  // One axis: move the estimate towards the sample by gain, round half away
  function automatic logic [EstW-1:0] correct_axis(input logic [EstW-1:0] est,
                                                    input logic signed [SampleW-1:0] sample,
                                                    input longint unsigned gain);
    longint          e;
    longint          diff;
    longint          res;
    longint unsigned mag;
    longint unsigned delta;
    e     = longint'($signed(est));
    diff  = longint'(sample) * 65536 - e;
    mag   = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
    delta = (mag * gain + (64'd1 << (FracW - 1))) >> FracW;
    res   = (diff < 0) ? e - longint'(delta) : e + longint'(delta);
    return res[EstW-1:0];
  endfunction

  // Kalman step for one accepted word; queues the estimates it yields
  function automatic void kalman_update(input logic signed [SampleW-1:0] z,
                                        input logic signed [SampleW-1:0] y);
    longint unsigned one_q30;
    longint unsigned pp;
    longint unsigned den;
    longint unsigned gain;
    estimate_pair_t  word;
    one_q30 = 64'(ONE_Q30);
    pp = 64'(shared_err_var) + 64'(noise_q);
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    den = pp + 64'(noise_r);
    // zero denominator gives unity gain
    if (den == 0) gain = one_q30;
    else gain = (pp << FracW) / den;
    if (gain > one_q30) gain = one_q30;
    track_z = correct_axis(track_z, z, gain);
    track_y = correct_axis(track_y, y, gain);
    shared_err_var = VarW'(((one_q30 - gain) * pp) >> FracW);
    word.z = track_z;
    word.y = track_y;
    pending_estimates.push_back(word);
  endfunction

  // Compare one output word with the oldest prediction
  task automatic check_estimates(input logic signed [EstW-1:0] got_z,
                                 input logic signed [EstW-1:0] got_y);
    estimate_pair_t want;
    if (pending_estimates.size() == 0) begin
      $display("%0t: unexpected word, z %0d y %0d", $time, got_z, got_y);
      error_count++;
    end else begin
      want = pending_estimates.pop_front();
      if (got_z !== want.z) begin
        $display("%0t: filtered_z expected %0d (%08h), got %0d (%08h)",
                 $time, want.z, want.z, got_z, got_z);
        error_count++;
      end
      if (got_y !== want.y) begin
        $display("%0t: filtered_y expected %0d (%08h), got %0d (%08h)",
                 $time, want.y, want.y, got_y, got_y);
        error_count++;
      end
    end
  endtask

  // Output monitor and random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      check_estimates(out_if.filtered_z, out_if.filtered_y);
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) stall_left = pick_stall();
    end
  end

  task automatic release_config();
    if (cfg_driving) begin
      cfg_if.valid <= 1'b0;
      cfg_driving = 1'b0;
    end
  endtask

  task automatic stop_feeding();
    if (feeding) begin
      in_if.valid <= 1'b0;
      feeding = 1'b0;
    end
  endtask

  // Send one sample pair and predict its result on acceptance
  task automatic send_sample(input logic signed [SampleW-1:0] z,
                             input logic signed [SampleW-1:0] y);
    int gap;
    gap = idling_on ? pick_gap() : 0;
    release_config();
    if (gap > 0) begin
      stop_feeding();
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.sample_z <= z;
    in_if.sample_y <= y;
    feeding = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    kalman_update(z, y);
  endtask

  // Hold the sender until every predicted word has come out
  task automatic wait_drained();
    stop_feeding();
    while (pending_estimates.size() != 0) @(posedge clk_i);
  endtask

  // Register write; valid is left high for back-to-back writes
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [VarW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_driving = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_PROCESS_NOISE:     noise_q = value;
      REG_MEASUREMENT_NOISE: noise_r = value;
      default: ;
    endcase
  endtask

  task automatic configure_noise(input logic [VarW-1:0] q, input logic [VarW-1:0] r);
    wait_drained();
    write_register(REG_PROCESS_NOISE, q);
    write_register(REG_MEASUREMENT_NOISE, r);
  endtask

  // Default noise, sample extremes on both axes
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // Zero noise: unity gain, then a zero denominator once the variance is gone
  task automatic test_gain_of_one();
    configure_noise(32'h0, 32'h0);
    send_sample(16'sd1234, -16'sd1234);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
  endtask

  // Predicted variance saturating at the top, and range limits
  task automatic test_variance_saturation();
    configure_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh5555, 16'shAAAA);
    configure_noise(32'h8000_0000, 32'h1);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0001, -16'sd2);
    configure_noise(32'h8000_0000, 32'h8000_0000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // Writes to unused indexes must leave both noise registers alone
  task automatic test_unknown_index();
    configure_noise(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST);
    write_register(REG_SPARE_A, 32'hFFFF_FFFF);
    write_register(REG_SPARE_B, 32'h0000_0000);
    write_register(REG_SPARE_A, 32'h0000_0000);
    write_register(REG_SPARE_B, 32'hFFFF_FFFF);
    send_sample(16'sd1000, -16'sd1000);
    send_sample(-16'sd20000, 16'sd20000);
    send_sample(16'sh7FFF, 16'sh8000);
  endtask

  // Random phases: slowly drifting gyro readings with noise, plus wild words
  task automatic test_random_phases();
    int                        phase;
    int                        n;
    int                        pick;
    logic signed [SampleW-1:0] base_z;
    logic signed [SampleW-1:0] base_y;
    logic signed [SampleW-1:0] z;
    logic signed [SampleW-1:0] y;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      configure_noise(pick_variance(1'b0), pick_variance(1'b1));
      // every fourth phase runs without idling
      idling_on = (phase % 4 != 3);
      base_z = SampleW'($urandom);
      base_y = SampleW'($urandom);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        if ($urandom_range(0, 49) == 0) begin
          base_z = SampleW'($urandom);
          base_y = SampleW'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          z = base_z + SampleW'($urandom_range(0, 64)) - SampleW'(32);
          y = base_y + SampleW'($urandom_range(0, 64)) - SampleW'(32);
        end else if (pick < 9) begin
          z = SampleW'($urandom);
          y = SampleW'($urandom);
        end else begin
          z = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        send_sample(z, y);
      end
    end
    idling_on = 1'b1;
  endtask

  // Sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_PROCESS_NOISE;
    cfg_if.data    = '0;
    in_if.valid    = 1'b0;
    in_if.sample_z = '0;
    in_if.sample_y = '0;
    out_if.ready   = 1'b0;
    track_z        = '0;
    track_y        = '0;
    shared_err_var = ERR_VAR_RST;
    noise_q        = PROCESS_NOISE_RST;
    noise_r        = MEASUREMENT_NOISE_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_gain_of_one();
    test_variance_saturation();
    test_unknown_index();
    test_random_phases();

    release_config();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tkf_pkg.sv
hw/rtl/tkf_in_if.sv
hw/rtl/tkf_out_if.sv
hw/rtl/tkf_cfg_if.sv
hw/rtl/tkf_gain_div.sv
hw/rtl/tkf_lane.sv
hw/rtl/tkf_merge.sv
hw/rtl/two_axis_scalar_kalman_filter_core.sv
verif/testbench.sv
